@@ rtl/core/fsp_pkg.sv @@
// Package for the file spec parser: parse phases, parser state record and the
// per-character helper functions used by the step logic; the top level uses the clear helper.
// No dependencies.
package fsp_pkg;

   localparam int NAME_MAX = 8;
   localparam int EXT_MAX  = 3;

   localparam logic [6:0]  CHAR_A       = 7'h41;
   localparam logic [6:0]  CHAR_P       = 7'h50;
   localparam logic [6:0]  CHAR_DOT     = 7'h2E;
   localparam logic [6:0]  CHAR_LBRACK  = 7'h5B;
   localparam logic [6:0]  CHAR_RBRACK  = 7'h5D;
   localparam logic [6:0]  CHAR_G       = 7'h47;
   localparam logic [7:0]  CHAR_COLON   = 8'h3A;
   localparam logic [6:0]  USER_LIMIT   = 7'd15;
   localparam logic [63:0] NAME_SPACES  = 64'h2020202020202020;
   localparam logic [23:0] EXT_SPACES   = 24'h202020;

   localparam logic CSR_CURRENT_DRIVE = 1'b0;
   localparam logic CSR_CURRENT_USER  = 1'b1;

   typedef enum logic [3:0] {
      PH_START,
      PH_HELD,
      PH_NAME,
      PH_EXT,
      PH_BRACKET,
      PH_DIGIT1,
      PH_DIGIT2,
      PH_CLOSE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [6:0]  held;
      logic [3:0]  name_count;
      logic [1:0]  ext_count;
      logic [63:0] name_buf;
      logic [23:0] ext_buf;
      logic [6:0]  drive;
      logic [6:0]  user;
      logic        error;
   } parse_state_type;

   function automatic parse_state_type fsp_clear();
      parse_state_type st;
      st.phase      = PH_START;
      st.held       = '0;
      st.name_count = '0;
      st.ext_count  = '0;
      st.name_buf   = NAME_SPACES;
      st.ext_buf    = EXT_SPACES;
      st.drive      = CHAR_A;
      st.user       = '0;
      st.error      = 1'b0;
      return st;
   endfunction

   function automatic logic fsp_is_punct(logic [6:0] c);
      return (c >= 7'h21 && c <= 7'h2F) || (c >= 7'h3A && c <= 7'h40) ||
             (c >= 7'h5B && c <= 7'h60) || (c >= 7'h7B && c <= 7'h7E);
   endfunction

   function automatic logic fsp_is_digit(logic [6:0] c);
      return c >= 7'h30 && c <= 7'h39;
   endfunction

   function automatic parse_state_type fsp_finish(parse_state_type st, logic err);
      parse_state_type r;
      r       = st;
      r.error = err;
      r.phase = PH_DONE;
      return r;
   endfunction

   function automatic parse_state_type fsp_name_char(parse_state_type st, logic [6:0] c);
      parse_state_type r;
      r = st;
      if (c != 7'd0 && r.name_count < 4'(NAME_MAX) && !fsp_is_punct(c)) begin
         for (int i = 0; i < 8; i++) begin
            if (r.name_count[2:0] == 3'(i)) begin
               r.name_buf[i*8 +: 8] = {1'b0, c};
            end
         end
         r.name_count = r.name_count + 4'd1;
      end else if (c == 7'd0) begin
         r = fsp_finish(r, 1'b0);
      end else if (c == CHAR_DOT) begin
         r.phase = PH_EXT;
      end else begin
         r = fsp_finish(r, 1'b1);
      end
      return r;
   endfunction

   function automatic parse_state_type fsp_ext_char(parse_state_type st, logic [6:0] c);
      parse_state_type r;
      r = st;
      if (c != 7'd0 && r.ext_count < 2'(EXT_MAX) && !fsp_is_punct(c)) begin
         for (int i = 0; i < 3; i++) begin
            if (r.ext_count == 2'(i)) begin
               r.ext_buf[i*8 +: 8] = {1'b0, c};
            end
         end
         r.ext_count = r.ext_count + 2'd1;
      end else if (c == 7'd0) begin
         r = fsp_finish(r, 1'b0);
      end else if (c == CHAR_LBRACK) begin
         r.phase = PH_BRACKET;
      end else begin
         r = fsp_finish(r, 1'b1);
      end
      return r;
   endfunction

   function automatic parse_state_type fsp_first_digit(parse_state_type st, logic [6:0] c);
      parse_state_type r;
      r = st;
      if (fsp_is_digit(c)) begin
         r.user  = {3'b000, c[3:0]};
         r.phase = PH_DIGIT2;
      end else begin
         r = fsp_finish(r, 1'b1);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/file_spec_parser_core.sv @@
// Top level of the file spec parser: configuration registers, parser state
// register and result register. Depends on fsp_pkg and fsp_char_step.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | req_char_code
//   rsp     | out       | rsp_valid/rsp_ready  | status, drive, user, name, extension
//   csr     | in        | csr_write_enable     | csr_index, csr_data
//
// One byte is accepted per cycle; the parser state is updated at the accepting edge.
// A zero byte loads the result register, and the result is offered on the next cycle.
// A waiting result stalls input only if it is not taken in the same cycle.
// Reset clears the configuration, the parser state and the result valid flag.
module file_spec_parser_core import fsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [6:0]  rsp_drive_letter,
   output logic [6:0]  rsp_user_area,
   output logic [63:0] rsp_name_chars,
   output logic [3:0]  rsp_name_length,
   output logic [23:0] rsp_ext_chars,
   output logic [1:0]  rsp_ext_length,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);

   logic [3:0]      cur_drive_ff;
   logic [3:0]      cur_user_ff;
   parse_state_type state_ff;
   parse_state_type step_result;
   parse_state_type step_next;
   logic            step_emit;
   logic            accept;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   parse_state_type rsp_ff;

   fsp_char_step u_step (
      .state      (state_ff),
      .cfg_drive  (cur_drive_ff),
      .cfg_user   (cur_user_ff),
      .char_code  (req_char_code),
      .result     (step_result),
      .next_state (step_next),
      .emit       (step_emit)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && step_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_drive_ff <= '0;
         cur_user_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CURRENT_DRIVE: cur_drive_ff <= csr_data;
            CSR_CURRENT_USER:  cur_user_ff  <= csr_data;
            default:           cur_drive_ff <= cur_drive_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsp_clear();
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= step_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.error;
   assign rsp_drive_letter = rsp_ff.drive;
   assign rsp_user_area    = rsp_ff.user;
   assign rsp_name_chars   = rsp_ff.name_buf;
   assign rsp_name_length  = rsp_ff.name_count;
   assign rsp_ext_chars    = rsp_ff.ext_buf;
   assign rsp_ext_length   = rsp_ff.ext_count;

endmodule

@@ rtl/core/fsp_char_step.sv @@
// Combinational next-state logic of the file spec parser for one path byte.
// Depends on fsp_pkg for the state record, phases and character helpers.
module fsp_char_step import fsp_pkg::*; (
   input  parse_state_type state,
   input  logic [3:0]      cfg_drive,
   input  logic [3:0]      cfg_user,
   input  logic [7:0]      char_code,
   output parse_state_type result,
   output parse_state_type next_state,
   output logic            emit
);

   parse_state_type cur;
   parse_state_type upd;
   logic [7:0]      upper;
   logic [6:0]      c;
   logic [6:0]      user_sum;

   always_comb begin
      cur = state;
      if (state.phase == PH_START) begin
         cur.drive = CHAR_A + {3'b000, cfg_drive};
         cur.user  = {3'b000, cfg_user};
      end
      upper    = (char_code >= 8'h61 && char_code <= 8'h7A) ? char_code - 8'h20 : char_code;
      c        = upper[6:0];
      user_sum = 7'({3'b000, cur.user[3:0]} * 7'd10) + {3'b000, c[3:0]};
      upd      = cur;
      case (cur.phase)
         PH_START: begin
            if (char_code == 8'd0) begin
               upd = fsp_finish(cur, 1'b1);
            end else if (c >= CHAR_A && c <= CHAR_P) begin
               upd.held  = c;
               upd.phase = PH_HELD;
            end else begin
               upd.phase = PH_NAME;
               upd       = fsp_name_char(upd, c);
            end
         end
         PH_HELD: begin
            upd.phase = PH_NAME;
            if (char_code == CHAR_COLON) begin
               upd.drive = cur.held;
            end else begin
               upd = fsp_name_char(fsp_name_char(upd, cur.held), c);
            end
         end
         PH_NAME: begin
            upd = fsp_name_char(cur, c);
         end
         PH_EXT: begin
            upd = fsp_ext_char(cur, c);
         end
         PH_BRACKET: begin
            if (c == CHAR_G) begin
               upd.phase = PH_DIGIT1;
            end else begin
               upd = fsp_first_digit(cur, c);
            end
         end
         PH_DIGIT1: begin
            upd = fsp_first_digit(cur, c);
         end
         PH_DIGIT2: begin
            if (fsp_is_digit(c)) begin
               upd.user = user_sum;
               if (user_sum > USER_LIMIT) begin
                  upd = fsp_finish(upd, 1'b1);
               end else begin
                  upd.phase = PH_CLOSE;
               end
            end else begin
               upd = fsp_finish(cur, c != CHAR_RBRACK);
            end
         end
         PH_CLOSE: begin
            upd = fsp_finish(cur, c != CHAR_RBRACK);
         end
         default: begin
            upd.phase = PH_DONE;
         end
      endcase
      emit       = (char_code == 8'd0);
      result     = upd;
      next_state = emit ? fsp_clear() : upd;
   end

endmodule

@@ sim/file_spec_parser_core_test.sv @@
// Self-checking testbench for file_spec_parser_core: directed paths and random
// paths under varied handshake pressure, checked against a local parser model or fixed expectations.
// Depends on fsp_pkg and file_spec_parser_core.
module file_spec_parser_core_test;
   import fsp_pkg::*;

   localparam int          CYCLE_LIMIT = 300000;
   localparam int          PHASE_BYTES = 120;
   localparam logic [63:0] BLANK_NAME  = 64'h2020202020202020;
   localparam logic [23:0] BLANK_EXT   = 24'h202020;
   localparam logic [6:0]  LETTER_A    = 7'h41;
   localparam logic [6:0]  LETTER_P    = 7'h50;
   localparam logic [6:0]  LETTER_G    = 7'h47;
   localparam logic [7:0]  KEY_COLON   = 8'h3A;
   localparam logic [7:0]  KEY_DOT     = 8'h2E;
   localparam logic [7:0]  KEY_LBRACK  = 8'h5B;
   localparam logic [7:0]  KEY_RBRACK  = 8'h5D;
   localparam logic [7:0]  KEY_ZERO    = 8'h30;
   localparam logic [7:0]  PATH_END    = 8'h00;

   typedef struct packed {
      logic        status;
      logic [6:0]  drive;
      logic [6:0]  user;
      logic [63:0] name;
      logic [3:0]  name_len;
      logic [23:0] ext;
      logic [1:0]  ext_len;
   } spec_type;

   typedef struct packed {
      logic [7:0] code;
      logic       typed;
      spec_type   want;
   } dir_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code    = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_status;
   logic [6:0]  rsp_drive_letter;
   logic [6:0]  rsp_user_area;
   logic [63:0] rsp_name_chars;
   logic [3:0]  rsp_name_length;
   logic [23:0] rsp_ext_chars;
   logic [1:0]  rsp_ext_length;
   logic        csr_write_enable = 1'b0;
   logic        csr_index        = 1'b0;
   logic [3:0]  csr_data         = 4'h0;

   file_spec_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_drive_letter (rsp_drive_letter),
      .rsp_user_area    (rsp_user_area),
      .rsp_name_chars   (rsp_name_chars),
      .rsp_name_length  (rsp_name_length),
      .rsp_ext_chars    (rsp_ext_chars),
      .rsp_ext_length   (rsp_ext_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   spec_type    pending_specs[$];
   dir_row_type directed_rows[$];
   logic [7:0]  path_bytes[$];
   int          errors         = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          hold_requests  = 0;
   int          holds_served   = 0;
   int          hold_left      = 0;
   int          cycle_count    = 0;

   logic [3:0]  cfg_drive;
   logic [3:0]  cfg_user;
   phase_type   ph;
   logic [6:0]  held_char;
   logic [3:0]  name_len;
   logic [1:0]  ext_len;
   logic [63:0] name_bytes;
   logic [23:0] ext_bytes;
   logic [6:0]  drv;
   logic [6:0]  usr;
   logic        err_bit;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit is_separator(logic [6:0] c);
      return (c >= 7'h21 && c <= 7'h2F) || (c >= 7'h3A && c <= 7'h40) ||
             (c >= 7'h5B && c <= 7'h60) || (c >= 7'h7B && c <= 7'h7E);
   endfunction

   function automatic bit is_decimal(logic [6:0] c);
      return c >= 7'h30 && c <= 7'h39;
   endfunction

   task automatic load_defaults();
      drv = LETTER_A + {3'b000, cfg_drive};
      usr = {3'b000, cfg_user};
   endtask

   task automatic restart_path();
      ph         = PH_START;
      held_char  = '0;
      name_len   = '0;
      ext_len    = '0;
      name_bytes = BLANK_NAME;
      ext_bytes  = BLANK_EXT;
      err_bit    = 1'b0;
      load_defaults();
   endtask

   task automatic close_parse(logic failed);
      err_bit = failed;
      ph      = PH_DONE;
   endtask

   task automatic take_name(logic [6:0] c);
      if (c != 7'd0 && name_len < 4'd8 && !is_separator(c)) begin
         name_bytes[8*name_len[2:0] +: 8] = {1'b0, c};
         name_len = name_len + 4'd1;
      end else if (c == 7'd0) begin
         close_parse(1'b0);
      end else if (c == KEY_DOT[6:0]) begin
         ph = PH_EXT;
      end else begin
         close_parse(1'b1);
      end
   endtask

   task automatic take_ext(logic [6:0] c);
      if (c != 7'd0 && ext_len < 2'd3 && !is_separator(c)) begin
         ext_bytes[8*ext_len +: 8] = {1'b0, c};
         ext_len = ext_len + 2'd1;
      end else if (c == 7'd0) begin
         close_parse(1'b0);
      end else if (c == KEY_LBRACK[6:0]) begin
         ph = PH_BRACKET;
      end else begin
         close_parse(1'b1);
      end
   endtask

   task automatic take_user_digit(logic [6:0] c);
      if (is_decimal(c)) begin
         usr = c - 7'h30;
         ph  = PH_DIGIT2;
      end else begin
         close_parse(1'b1);
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, output bit produced, output spec_type res);
      logic [7:0] up;
      logic [6:0] c;
      int         total;
      up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
      c  = up[6:0];
      case (ph)
         PH_START: begin
            load_defaults();
            if (b == PATH_END) begin
               close_parse(1'b1);
            end else if (c >= LETTER_A && c <= LETTER_P) begin
               held_char = c;
               ph        = PH_HELD;
            end else begin
               ph = PH_NAME;
               take_name(c);
            end
         end
         PH_HELD: begin
            ph = PH_NAME;
            if (b == KEY_COLON) begin
               drv = held_char;
            end else begin
               take_name(held_char);
               take_name(c);
            end
         end
         PH_NAME: take_name(c);
         PH_EXT: take_ext(c);
         PH_BRACKET: begin
            if (c == LETTER_G) ph = PH_DIGIT1;
            else take_user_digit(c);
         end
         PH_DIGIT1: take_user_digit(c);
         PH_DIGIT2: begin
            if (is_decimal(c)) begin
               total = int'(usr[3:0]) * 10 + int'(c) - 48;
               usr   = total[6:0];
               if (total > 15) close_parse(1'b1);
               else ph = PH_CLOSE;
            end else begin
               close_parse(c != KEY_RBRACK[6:0]);
            end
         end
         PH_CLOSE: close_parse(c != KEY_RBRACK[6:0]);
         default: ph = PH_DONE;
      endcase
      produced = (b == PATH_END);
      res      = '0;
      if (produced) begin
         res = '{err_bit, drv, usr, name_bytes, name_len, ext_bytes, ext_len};
         restart_path();
      end
   endtask

   task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
         errors++;
      end
   endtask

   task automatic check_spec();
      spec_type want;
      if (pending_specs.size() == 0) begin
         $display("%0t: result transaction with no expectation pending", $time);
         errors++;
      end else begin
         want = pending_specs.pop_front();
         compare_field("status", 64'(want.status), 64'(rsp_status));
         compare_field("drive_letter", 64'(want.drive), 64'(rsp_drive_letter));
         compare_field("user_area", 64'(want.user), 64'(rsp_user_area));
         compare_field("name_chars", want.name, rsp_name_chars);
         compare_field("name_length", 64'(want.name_len), 64'(rsp_name_length));
         compare_field("ext_chars", 64'(want.ext), 64'(rsp_ext_chars));
         compare_field("ext_length", 64'(want.ext_len), 64'(rsp_ext_length));
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_spec();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = 299;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("file_spec_parser_core_test: errors");
      $finish;
   end

   task automatic send_byte(input logic [7:0] code);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_config(input logic [3:0] drive_num, input logic [3:0] user_num);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CURRENT_DRIVE;
      csr_data         <= drive_num;
      @(posedge clock);
      csr_index <= CSR_CURRENT_USER;
      csr_data  <= user_num;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_drive = drive_num;
      cfg_user  = user_num;
   endtask

   task automatic drain_results();
      while (pending_specs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_text(string s);
      dir_row_type row;
      for (int i = 0; i < s.len(); i++) begin
         row.code  = s[i];
         row.typed = 1'b0;
         row.want  = '0;
         directed_rows.push_back(row);
      end
   endtask

   task automatic add_code(logic [7:0] code, logic typed, spec_type want);
      dir_row_type row;
      row.code  = code;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] name_byte();
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k < 8) return 8'(8'h41 + $urandom_range(0, 25));
      if (k < 12) return 8'(8'h61 + $urandom_range(0, 25));
      if (k < 15) return 8'(8'h30 + $urandom_range(0, 9));
      if (k == 15) return 8'h20;
      if (k == 16) return 8'($urandom_range(1, 31));
      if (k == 17) return 8'h7F;
      return 8'(8'hC1 + $urandom_range(0, 25));
   endfunction

   task automatic fill_path();
      int unsigned pick;
      int unsigned n;
      int unsigned u;
      path_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         n = $urandom_range(0, 12);
         repeat (n) path_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         if ($urandom_range(0, 99) < 35) begin
            path_bytes.push_back(8'(8'h41 + $urandom_range(0, 15) + 32 * $urandom_range(0, 1)));
            path_bytes.push_back(KEY_COLON);
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
         repeat (n) path_bytes.push_back(name_byte());
         if ($urandom_range(0, 99) < 65) begin
            path_bytes.push_back(KEY_DOT);
            n = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3);
            repeat (n) path_bytes.push_back(name_byte());
            if ($urandom_range(0, 99) < 55) begin
               path_bytes.push_back(KEY_LBRACK);
               if ($urandom_range(0, 1) == 1)
                  path_bytes.push_back(8'({1'b0, LETTER_G} + 32 * $urandom_range(0, 1)));
               u = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 99) : $urandom_range(0, 15);
               if (u >= 10 || $urandom_range(0, 2) == 0) path_bytes.push_back(8'(KEY_ZERO + u / 10));
               path_bytes.push_back(8'(KEY_ZERO + u % 10));
               if ($urandom_range(0, 9) != 0) path_bytes.push_back(KEY_RBRACK);
            end
         end
         if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 3)) path_bytes.push_back(8'($urandom_range(1, 255)));
         if (pick >= 70 && path_bytes.size() > 0)
            path_bytes[$urandom_range(0, path_bytes.size() - 1)] = 8'($urandom_range(1, 255));
      end
      path_bytes.push_back(PATH_END);
   endtask

   initial begin
      spec_type    predicted;
      bit          produced;
      int          phase_bytes;
      logic [3:0]  drive_num;
      logic [3:0]  user_num;
      cfg_drive = '0;
      cfg_user  = '0;
      restart_path();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_config(4'd15, 4'd15);

      add_code(PATH_END, 1'b1, '{1'b1, LETTER_P, 7'd15, BLANK_NAME, 4'd0, BLANK_EXT, 2'd0});
      add_text("b:x.c[g15]?");
      add_code(PATH_END, 1'b0, '0);
      add_text("P.ABCD");
      add_code(PATH_END, 1'b1,
               '{1'b1, LETTER_P, 7'd15, 64'h2020202020202050, 4'd1, 24'h434241, 2'd3});
      add_text(".[99");
      add_code(PATH_END, 1'b1, '{1'b1, LETTER_P, 7'd99, BLANK_NAME, 4'd0, BLANK_EXT, 2'd0});
      add_code(8'h80, 1'b0, '0);
      add_code(8'hFF, 1'b0, '0);
      add_code(PATH_END, 1'b1, '{1'b0, LETTER_P, 7'd15, BLANK_NAME, 4'd0, BLANK_EXT, 2'd0});

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].code);
         parse_byte(directed_rows[i].code, produced, predicted);
         if (produced) pending_specs.push_back(directed_rows[i].typed ?
                                               directed_rows[i].want : predicted);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < 5; p++) begin
         drain_results();
         case (p)
            0: begin drive_num = 4'd0;  user_num = 4'd0;  end
            1: begin drive_num = 4'd15; user_num = 4'd0;  end
            2: begin drive_num = 4'd0;  user_num = 4'd15; end
            default: begin
               drive_num = 4'($urandom_range(0, 15));
               user_num  = 4'($urandom_range(0, 15));
            end
         endcase
         write_config(drive_num, user_num);
         send_idle_pct  = (p == 1) ? 76 : (p == 3) ? 11 : 0;
         recv_stall_pct = (p == 2) ? 76 : (p == 3) ? 11 : 0;
         if (p == 4) hold_requests++;
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            fill_path();
            foreach (path_bytes[i]) begin
               send_byte(path_bytes[i]);
               parse_byte(path_bytes[i], produced, predicted);
               if (produced) pending_specs.push_back(predicted);
            end
            phase_bytes += path_bytes.size();
         end
         req_valid <= 1'b0;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_specs.size() == 0) begin
         $display("file_spec_parser_core_test: clean");
      end else begin
         $display("file_spec_parser_core_test: errors");
      end
      $finish;
   end
endmodule

@@ file_spec_parser_core.f @@
rtl/core/fsp_pkg.sv
rtl/core/fsp_char_step.sv
rtl/core/file_spec_parser_core.sv
sim/file_spec_parser_core_test.sv
